// ----- rtl/bbd_pkg.sv -----
// Shared types, constants and helper functions for the binary to blanked
// decimal digit converter. No dependencies.
`default_nettype none

package bbd_pkg;

  // Field widths fixed by the interface
  localparam int unsigned VALUE_W = 27;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CODE_W  = 4;

  // Conversion step counter covers one step per input bit
  localparam int unsigned CNT_W = $clog2(VALUE_W);

  // Code written to a position above the most significant digit
  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

  // Decimal digit threshold and correction for the shift-and-add-3 step
  localparam logic [CODE_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [CODE_W-1:0] DIGIT_ADJ     = 4'd3;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VALUE_W-1:0] value_t;

  // One queue slot transfer: valid flag plus the saturated value
  typedef struct packed {
    logic   valid;
    value_t value;
  } q_item_t;

  // Largest value that fits in count decimal digits (elaboration only)
  function automatic value_t value_limit(input int unsigned count);
    logic [31:0] lim;
    lim = 32'd1;
    for (int unsigned i = 0; i < count; i++) begin
      lim = lim * 32'd10;
    end
    return value_t'(lim - 32'd1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bbd_front.sv -----
// Front stage: accepts input items, saturates them to the displayable range
// and pushes them into the queue. Depends on bbd_pkg.
`default_nettype none

module bbd_front #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_valid_i,
  output logic                 s_ready_o,
  input  wire bbd_pkg::value_t value_i,
  output bbd_pkg::q_item_t     push_o,
  input  wire                  push_ready_i
);

  localparam bbd_pkg::value_t LIMIT = bbd_pkg::value_limit(DIGIT_COUNT);

  logic            valid_q, valid_d;
  bbd_pkg::value_t value_q, value_d;

  // Accept when the holding register is free or drains this cycle
  assign s_ready_o = !valid_q || push_ready_i;

  // Clamp oversized values to all nines
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (push_ready_i) begin
      valid_d = 1'b0;
    end
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
      value_d = (value_i > LIMIT) ? LIMIT : value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign push_o.valid = valid_q;
  assign push_o.value = value_q;

endmodule

`default_nettype wire

// ----- rtl/bbd_queue.sv -----
// Short FIFO that decouples the front stage from the conversion back end.
// Depends on bbd_pkg.
`default_nettype none

module bbd_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire bbd_pkg::q_item_t wr_i,
  output logic             wr_ready_o,
  output bbd_pkg::q_item_t rd_o,
  input  wire              rd_pop_i
);

  bbd_pkg::value_t                   mem_q [bbd_pkg::QUEUE_DEPTH];
  logic [bbd_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [bbd_pkg::QCNT_W-1:0]        count_q;
  logic                              push, pop;

  assign wr_ready_o = (count_q != bbd_pkg::QCNT_W'(bbd_pkg::QUEUE_DEPTH));
  assign push       = wr_i.valid && wr_ready_o;
  assign pop        = rd_pop_i && (count_q != '0);

  assign rd_o.valid = (count_q != '0);
  assign rd_o.value = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == bbd_pkg::QPTR_W'(bbd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == bbd_pkg::QPTR_W'(bbd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store pushed values
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bbd_back.sv -----
// Back end: converts one queued value to BCD by shift-and-add-3, one bit a
// cycle, then emits one digit write per position. Depends on bbd_pkg.
`default_nettype none

module bbd_back #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire bbd_pkg::q_item_t              rd_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [bbd_pkg::POS_W-1:0]          out_pos_o,
  output logic [bbd_pkg::CODE_W-1:0]         out_code_o,
  output logic                               out_last_o
);

  localparam int unsigned BCD_W = bbd_pkg::CODE_W * DIGIT_COUNT;
  localparam logic [bbd_pkg::POS_W-1:0] LAST_POS = bbd_pkg::POS_W'(DIGIT_COUNT);
  localparam logic [bbd_pkg::CNT_W-1:0] LAST_STEP = bbd_pkg::CNT_W'(bbd_pkg::VALUE_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  bbd_pkg::value_t               bin_q, bin_d;
  logic [BCD_W-1:0]              bcd_q, bcd_d, bcd_adj;
  logic [bbd_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [bbd_pkg::POS_W-1:0]     pos_q, pos_d;
  logic                          out_valid_q, out_valid_d;
  logic [bbd_pkg::POS_W-1:0]     out_pos_q, out_pos_d;
  logic [bbd_pkg::CODE_W-1:0]    out_code_q, out_code_d;
  logic                          out_last_q, out_last_d;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int unsigned i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd_q[i*bbd_pkg::CODE_W +: bbd_pkg::CODE_W] >= bbd_pkg::DIGIT_ADJ_MIN) begin
        bcd_adj[i*bbd_pkg::CODE_W +: bbd_pkg::CODE_W] =
          bcd_q[i*bbd_pkg::CODE_W +: bbd_pkg::CODE_W] + bbd_pkg::DIGIT_ADJ;
      end else begin
        bcd_adj[i*bbd_pkg::CODE_W +: bbd_pkg::CODE_W] =
          bcd_q[i*bbd_pkg::CODE_W +: bbd_pkg::CODE_W];
      end
    end
  end

  assign pop_o = (state_q == ST_IDLE) && rd_i.valid;

  // Sequence load, conversion steps and digit writes
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (rd_i.valid) begin
          bin_d   = rd_i.value;
          bcd_d   = '0;
          cnt_d   = '0;
          pos_d   = bbd_pkg::POS_W'(1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[bbd_pkg::VALUE_W-1]};
        bin_d = {bin_q[bbd_pkg::VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          // Blank once no significant digit remains
          out_code_d  = (bcd_q != '0) ? bcd_q[bbd_pkg::CODE_W-1:0] : bbd_pkg::BLANK_CODE;
          out_last_d  = (pos_q == LAST_POS);
          bcd_d       = bcd_q >> bbd_pkg::CODE_W;
          pos_d       = pos_q + 1'b1;
          if (pos_q == LAST_POS) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_pos_q  <= out_pos_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/binary_to_blanked_decimal_digits_core.sv -----
// An accepted value passes the front holding register and the queue; the back
// end then converts it by bit-serial shift-and-add-3 (27 steps) and writes
// positions 1..DIGIT_COUNT, on consecutive cycles while m_axis_tready is high.
// The back end takes a new value only after its last digit write is issued.
// A two-entry queue lets new values be taken while a conversion runs.
// Reset: asynchronous, active low; clears all handshake and sequencer state.
`default_nettype none

module binary_to_blanked_decimal_digits_core #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [26:0] value, [31:27] zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] digit_position, [7:4] digit_code
  output logic        m_axis_tlast    // last
);

  bbd_pkg::q_item_t             push, rd;
  logic                         push_ready, pop;
  logic [bbd_pkg::POS_W-1:0]    out_pos;
  logic [bbd_pkg::CODE_W-1:0]   out_code;

  bbd_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .value_i     (s_axis_tdata[bbd_pkg::VALUE_W-1:0]),
    .push_o      (push),
    .push_ready_i(push_ready)
  );

  bbd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_ready_o(push_ready),
    .rd_o      (rd),
    .rd_pop_i  (pop)
  );

  bbd_back #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_pos_o  (out_pos),
    .out_code_o (out_code),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {out_code, out_pos};

endmodule

`default_nettype wire

// ----- rtl/bbd_checker.sv -----
// Port-level checks for the binary to blanked decimal digit converter,
// bound to the top level. Depends on bbd_pkg.
`default_nettype none

module bbd_checker #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tlast
);

  logic [bbd_pkg::POS_W-1:0]  exp_pos_q;
  logic                       blank_q;
  logic [bbd_pkg::POS_W-1:0]  pos;
  logic [bbd_pkg::CODE_W-1:0] code;
  logic                       out_fire;

  assign pos      = m_axis_tdata[3:0];
  assign code     = m_axis_tdata[7:4];
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Track expected position and whether a blank has appeared in this run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= bbd_pkg::POS_W'(1);
      blank_q   <= 1'b0;
    end else if (out_fire) begin
      exp_pos_q <= m_axis_tlast ? bbd_pkg::POS_W'(1) : exp_pos_q + 1'b1;
      blank_q   <= m_axis_tlast ? 1'b0 : (blank_q || (code == bbd_pkg::BLANK_CODE));
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (pos == bbd_pkg::POS_W'(DIGIT_COUNT))))
    else $error("tlast does not match final position");

  a_pos_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pos == exp_pos_q))
    else $error("digit position out of sequence");

  a_blank_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && blank_q |-> (code == bbd_pkg::BLANK_CODE))
    else $error("digit after a blank position");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (code <= 4'd9) || (code == bbd_pkg::BLANK_CODE))
    else $error("illegal digit code");

endmodule

bind binary_to_blanked_decimal_digits_core bbd_checker #(
  .DIGIT_COUNT(DIGIT_COUNT)
) u_bbd_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for binary_to_blanked_decimal_digits_core.
// Depends on bbd_pkg and the core; predicts the eight digit writes per value.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DIGIT_COUNT = 8;
  localparam int unsigned MAX_VALUE   = 134217727;  // all ones over the value field
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [bbd_pkg::POS_W-1:0]  position;
    logic [bbd_pkg::CODE_W-1:0] code;
    logic                       last;
  } digit_write_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [26:0] value, [31:27] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [3:0] digit_position, [7:4] digit_code
  logic        m_axis_tlast;         // last

  digit_write_t pending_writes[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  sink_stall_left = 0;
  bit           src_idle_on  = 1'b1;
  bit           sink_idle_on = 1'b1;

  binary_to_blanked_decimal_digits_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Generate the 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // Saturate a value to all nines and split it into blanked decimal digits, least significant first
  function automatic void predict_digits(input logic [bbd_pkg::VALUE_W-1:0] value);
    int unsigned  rem;
    digit_write_t w;
    rem = value;
    if (rem > pow10(DIGIT_COUNT) - 1) rem = pow10(DIGIT_COUNT) - 1;
    for (int unsigned pos = 1; pos <= DIGIT_COUNT; pos++) begin
      w.position = bbd_pkg::POS_W'(pos);
      if (rem > 0) begin
        w.code = bbd_pkg::CODE_W'(rem % 10);
        rem    = rem / 10;
      end else begin
        w.code = bbd_pkg::BLANK_CODE;
      end
      w.last = (pos == DIGIT_COUNT);
      pending_writes.push_back(w);
    end
  endfunction

  // Mostly values with a random digit count, plus zero, saturation and raw bits
  function automatic logic [bbd_pkg::VALUE_W-1:0] pick_value();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return '0;
      1: return bbd_pkg::VALUE_W'($urandom_range(pow10(DIGIT_COUNT), MAX_VALUE));
      2, 3: return bbd_pkg::VALUE_W'($urandom());
      default: begin
        n = $urandom_range(1, DIGIT_COUNT);
        return bbd_pkg::VALUE_W'($urandom_range(pow10(n - 1), pow10(n) - 1));
      end
    endcase
  endfunction

  // Offer one value, optionally after an idle burst, and hold it until taken
  task automatic send_value(input logic [bbd_pkg::VALUE_W-1:0] value);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digits(value);
  endtask

  // Drop valid and hold off until every predicted write has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_value('0);
    send_value(bbd_pkg::VALUE_W'(1));
    send_value(bbd_pkg::VALUE_W'(9));
    send_value(bbd_pkg::VALUE_W'(10));
    send_value(bbd_pkg::VALUE_W'(99));
    send_value(bbd_pkg::VALUE_W'(100));
    send_value(bbd_pkg::VALUE_W'(1000000));
    send_value(bbd_pkg::VALUE_W'(9999999));
    send_value(bbd_pkg::VALUE_W'(10000000));
    send_value(bbd_pkg::VALUE_W'(12345678));
    send_value(bbd_pkg::VALUE_W'(87654321));
    send_value(bbd_pkg::VALUE_W'(99999999));
    send_value(bbd_pkg::VALUE_W'(100000000));
    send_value(bbd_pkg::VALUE_W'(MAX_VALUE));
    send_value(bbd_pkg::VALUE_W'('h5555555));
    send_value(bbd_pkg::VALUE_W'('h2AAAAAA));
    send_value(bbd_pkg::VALUE_W'(10203040));
    send_value('0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_value(pick_value());
    wait_drained();
    // back-to-back values right after the queue has emptied
    src_idle_on = 1'b0;
    for (int i = 0; i < 6; i++) send_value(pick_value());
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_value(pick_value());
  endtask

  // Random stall bursts on the result side
  always @(posedge clk_i) begin
    if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready   <= 1'b0;
      sink_stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted write with the oldest prediction
  always @(posedge clk_i) begin
    digit_write_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected write pos=%0d code=%0d last=%0b", $realtime,
                   m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tlast);
      end else begin
        want = pending_writes.pop_front();
        if (want.position !== m_axis_tdata[3:0] || want.code !== m_axis_tdata[7:4] ||
            want.last !== m_axis_tlast) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: expected pos=%0d code=%0d last=%0b, got pos=%0d code=%0d last=%0b",
                     $realtime, want.position, want.code, want.last,
                     m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tlast);
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_extremes();
    test_drain_pause();
    test_random(260);

    // finish without idling on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random(40);

    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
